### design/skl_pkg.sv
// ----------------------------------------------------------------------------
// skl_pkg
// Shared constants and types for the step keyframe lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package skl_pkg;

    localparam int MAX_KEYS = 256;
    localparam int ADDR_W   = $clog2(MAX_KEYS);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;
    localparam int ENTRY_W  = 2 * DATA_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     empty;
    } skl_result_t;

endpackage

`default_nettype wire

### design/skl_ram.sv
// ----------------------------------------------------------------------------
// skl_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

### design/skl_search.sv
// ----------------------------------------------------------------------------
// skl_search
// Key table writer and binary search sequencer around one key memory.
// ----------------------------------------------------------------------------
`default_nettype none

module skl_search (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic                                 s_cmd,
    input  wire logic [7:0]                           s_key_index,
    input  wire logic signed [skl_pkg::DATA_W-1:0]    s_key_time,
    input  wire logic signed [skl_pkg::DATA_W-1:0]    s_key_value,
    input  wire logic signed [skl_pkg::DATA_W-1:0]    s_query_time,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [skl_pkg::CNT_W-1:0]            cfg_data,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output skl_pkg::skl_result_t                      res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST_CHK,
        S_LAST_CHK,
        S_MID_CHK,
        S_DONE
    } state_t;

    state_t                                state_reg, state_next;
    logic [skl_pkg::CNT_W-1:0]             key_count_reg, key_count_next;
    logic [skl_pkg::CNT_W-1:0]             n_reg, n_next;
    logic signed [skl_pkg::DATA_W-1:0]     t_reg, t_next;
    logic [skl_pkg::ADDR_W-1:0]            lo_reg, lo_next;
    logic [skl_pkg::ADDR_W-1:0]            hi_reg, hi_next;
    logic [skl_pkg::ADDR_W-1:0]            mid_reg, mid_next;
    logic signed [skl_pkg::DATA_W-1:0]     lo_val_reg, lo_val_next;
    logic signed [skl_pkg::DATA_W-1:0]     hi_time_reg, hi_time_next;
    logic signed [skl_pkg::DATA_W-1:0]     hi_val_reg, hi_val_next;
    skl_pkg::skl_result_t                  res_reg, res_next;

    logic                                  ram_we;
    logic [skl_pkg::ADDR_W-1:0]            ram_addr;
    logic [skl_pkg::ENTRY_W-1:0]           ram_wdata;
    logic [skl_pkg::ENTRY_W-1:0]           ram_rdata;
    logic signed [skl_pkg::DATA_W-1:0]     rd_time;
    logic signed [skl_pkg::DATA_W-1:0]     rd_value;

    logic                                  in_accept;
    logic [skl_pkg::CNT_W-1:0]             n_clamped;
    logic [skl_pkg::CNT_W-1:0]             n_minus1;
    logic                                  go_hi;
    logic [skl_pkg::ADDR_W-1:0]            lo_cand;
    logic [skl_pkg::ADDR_W-1:0]            hi_cand;
    logic signed [skl_pkg::DATA_W-1:0]     lo_val_cand;
    logic signed [skl_pkg::DATA_W-1:0]     hi_time_cand;
    logic signed [skl_pkg::DATA_W-1:0]     hi_val_cand;
    logic [skl_pkg::CNT_W-1:0]             idx_sum;
    logic                                  narrow;

    skl_ram #(
        .WIDTH (skl_pkg::ENTRY_W),
        .DEPTH (skl_pkg::MAX_KEYS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_time   = ram_rdata[skl_pkg::ENTRY_W-1:skl_pkg::DATA_W];
    assign rd_value  = ram_rdata[skl_pkg::DATA_W-1:0];
    assign ram_wdata = {s_key_time, s_key_value};

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    assign n_clamped = (key_count_reg > skl_pkg::CNT_W'(skl_pkg::MAX_KEYS))
                     ? skl_pkg::CNT_W'(skl_pkg::MAX_KEYS) : key_count_reg;
    assign n_minus1  = n_reg - skl_pkg::CNT_W'(1);

    // Narrow the bracket around the key just read.
    assign go_hi        = (state_reg == S_LAST_CHK) || (t_reg <= rd_time);
    assign lo_cand      = go_hi ? lo_reg : mid_reg;
    assign hi_cand      = go_hi ? mid_reg : hi_reg;
    assign lo_val_cand  = go_hi ? lo_val_reg : rd_value;
    assign hi_time_cand = go_hi ? rd_time : hi_time_reg;
    assign hi_val_cand  = go_hi ? rd_value : hi_val_reg;
    assign idx_sum      = {1'b0, lo_cand} + {1'b0, hi_cand};
    assign narrow       = ({1'b0, hi_cand} > ({1'b0, lo_cand} + skl_pkg::CNT_W'(1)));

    always_comb begin
        state_next     = state_reg;
        key_count_next = key_count_reg;
        n_next         = n_reg;
        t_next         = t_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        lo_val_next    = lo_val_reg;
        hi_time_next   = hi_time_reg;
        hi_val_next    = hi_val_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_addr       = '0;

        if (cfg_valid && cfg_ready) begin
            key_count_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (s_cmd == skl_pkg::CMD_WRITE) begin
                        ram_addr = s_key_index[skl_pkg::ADDR_W-1:0];
                        ram_we   = ({1'b0, s_key_index} < skl_pkg::CNT_W'(skl_pkg::MAX_KEYS));
                    end else begin
                        t_next = s_query_time;
                        n_next = n_clamped;
                        if (n_clamped == '0) begin
                            res_next.value = '0;
                            res_next.empty = 1'b1;
                            state_next     = S_DONE;
                        end else begin
                            state_next = S_FIRST_CHK;
                        end
                    end
                end
            end
            S_FIRST_CHK: begin
                if (n_reg == skl_pkg::CNT_W'(1) || t_reg <= rd_time) begin
                    res_next.value = rd_value;
                    res_next.empty = 1'b0;
                    state_next     = S_DONE;
                end else begin
                    lo_next     = '0;
                    lo_val_next = rd_value;
                    mid_next    = n_minus1[skl_pkg::ADDR_W-1:0];
                    ram_addr    = n_minus1[skl_pkg::ADDR_W-1:0];
                    state_next  = S_LAST_CHK;
                end
            end
            S_LAST_CHK, S_MID_CHK: begin
                if (state_reg == S_LAST_CHK && t_reg >= rd_time) begin
                    res_next.value = rd_value;
                    res_next.empty = 1'b0;
                    state_next     = S_DONE;
                end else begin
                    lo_next      = lo_cand;
                    hi_next      = hi_cand;
                    lo_val_next  = lo_val_cand;
                    hi_time_next = hi_time_cand;
                    hi_val_next  = hi_val_cand;
                    if (narrow) begin
                        mid_next   = idx_sum[skl_pkg::CNT_W-1:1];
                        ram_addr   = idx_sum[skl_pkg::CNT_W-1:1];
                        state_next = S_MID_CHK;
                    end else begin
                        res_next.value = (hi_time_cand == t_reg) ? hi_val_cand : lo_val_cand;
                        res_next.empty = 1'b0;
                        state_next     = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            key_count_reg <= '0;
        end else begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
        end
        n_reg       <= n_next;
        t_reg       <= t_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        lo_val_reg  <= lo_val_next;
        hi_time_reg <= hi_time_next;
        hi_val_reg  <= hi_val_next;
        res_reg     <= res_next;
    end

endmodule

`default_nettype wire

### design/step_keyframe_lookup.sv
// ----------------------------------------------------------------------------
// step_keyframe_lookup
// Step keyframe table with binary search lookup and a registered result.
// ----------------------------------------------------------------------------
// A write item (tuser 0) stores one key. A query item (tuser 1) runs a binary
// search over the n keys in use, at most 256, and ends early when the time
// falls at or outside either end; an empty table answers with table_empty set.
// Every step of the search is one read of the single key memory port followed
// by a compare on the returned key. One item is worked on at a time; the next
// is taken while a finished result still waits in the output register.
`default_nettype none

module step_keyframe_lookup (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // key_index[7:0], key_time[39:8], key_value[71:40], query_time[103:72]
    input  wire logic [103:0]                 s_tdata,
    // command[0]
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // sampled_value[31:0]
    output logic [31:0]                       m_tdata,
    // table_empty[0]
    output logic                              m_tuser,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [skl_pkg::CNT_W-1:0]    cfg_data
);

    logic                  res_valid;
    logic                  res_ready;
    skl_pkg::skl_result_t  res;
    logic                  out_valid_reg, out_valid_next;
    skl_pkg::skl_result_t  out_res_reg, out_res_next;

    skl_search u_search (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_cmd        (s_tuser),
        .s_key_index  (s_tdata[7:0]),
        .s_key_time   (s_tdata[39:8]),
        .s_key_value  (s_tdata[71:40]),
        .s_query_time (s_tdata[103:72]),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.value;
    assign m_tuser  = out_res_reg.empty;

endmodule

`default_nettype wire

### sim/step_keyframe_lookup_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_keyframe_lookup_tb
// Self-checking bench for the step keyframe lookup. Loads keyframe tables of
// many sizes and shapes (sorted, with repeated times, unsorted), changes the
// key count between phases, and queries times at keys, beside keys, at the
// range extremes and at random. A scoreboard class predicts every lookup
// from its own copy of the table and checks each result in order, while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module step_keyframe_lookup_tb;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int TARGET_ITEMS    = 1750;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;
    localparam int CNT_MAX         = (1 << skl_pkg::CNT_W) - 1;
    localparam logic signed [skl_pkg::DATA_W-1:0] TIME_MIN = 32'sh8000_0000;
    localparam logic signed [skl_pkg::DATA_W-1:0] TIME_MAX = 32'sh7FFF_FFFF;

    class keyframe_scoreboard;
        logic signed [skl_pkg::DATA_W-1:0] key_time_q  [skl_pkg::MAX_KEYS];
        logic signed [skl_pkg::DATA_W-1:0] key_value_q [skl_pkg::MAX_KEYS];
        int unsigned                       key_count_q = 0;
        skl_pkg::skl_result_t              lookups_due [$];
        int unsigned                       failures = 0;

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t: mismatch: %s", $time, msg);
        endfunction

        function void set_key_count(int unsigned n);
            key_count_q = n;
        endfunction

        function skl_pkg::skl_result_t step_value(logic signed [skl_pkg::DATA_W-1:0] t);
            skl_pkg::skl_result_t r;
            int unsigned n, lo, hi, mid;
            n = (key_count_q > skl_pkg::MAX_KEYS) ? skl_pkg::MAX_KEYS : key_count_q;
            r.empty = 1'b0;
            r.value = '0;
            if (n == 0) begin
                r.empty = 1'b1;
            end else if (n == 1 || t <= key_time_q[0]) begin
                r.value = key_value_q[0];
            end else if (t >= key_time_q[n-1]) begin
                r.value = key_value_q[n-1];
            end else begin
                lo = 0;
                hi = n - 1;
                while (lo + 1 != hi && lo != hi) begin
                    mid = (lo + hi) / 2;
                    if (t <= key_time_q[mid])
                        hi = mid;
                    else
                        lo = mid;
                end
                r.value = (key_time_q[hi] == t) ? key_value_q[hi] : key_value_q[lo];
            end
            return r;
        endfunction

        function void note_item(logic cmd, logic [103:0] data);
            if (cmd == skl_pkg::CMD_WRITE) begin
                key_time_q[data[7:0]]  = data[39:8];
                key_value_q[data[7:0]] = data[71:40];
            end else begin
                lookups_due.push_back(step_value(data[103:72]));
            end
        endfunction

        function void check_lookup(logic [skl_pkg::DATA_W-1:0] value, logic empty);
            skl_pkg::skl_result_t due;
            if (lookups_due.size() == 0) begin
                flag($sformatf("unexpected result value=%h empty=%b", value, empty));
                return;
            end
            due = lookups_due.pop_front();
            if (value !== due.value)
                flag($sformatf("sampled_value exp %h got %h", due.value, value));
            if (empty !== due.empty)
                flag($sformatf("table_empty exp %b got %b", due.empty, empty));
        endfunction
    endclass

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [103:0]               s_tdata   = '0;
    logic                       s_tuser   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [31:0]                m_tdata;
    logic                       m_tuser;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [skl_pkg::CNT_W-1:0]  cfg_data  = '0;

    keyframe_scoreboard                sb;
    logic signed [skl_pkg::DATA_W-1:0] gen_time [skl_pkg::MAX_KEYS];
    int unsigned                       items_sent   = 0;
    int unsigned                       idle_cycles  = 0;
    int unsigned                       results_seen = 0;
    int unsigned                       hold_left    = 0;
    int unsigned                       rx_gap_left  = 0;
    bit                                sender_burst   = 1'b0;
    bit                                receiver_burst = 1'b0;
    bit                                hold_off_req   = 1'b0;

    step_keyframe_lookup dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_lookup(m_tdata, m_tuser);
                results_seen++;
                if (results_seen % 64 == 0)
                    receiver_burst = ($urandom_range(0, 2) == 0);
                rx_gap_left = receiver_burst ? 0 : $urandom_range(0, 7);
            end
            if (hold_off_req) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (rx_gap_left > 0) begin
            m_tready <= 1'b0;
            rx_gap_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [103:0] data, input bit ask_hold = 0);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (ask_hold)
            hold_off_req = 1'b1;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(cmd, data);
        items_sent++;
    endtask

    task automatic write_key(input logic [7:0] slot, input logic [31:0] kt, input logic [31:0] kv);
        gen_time[slot] = kt;
        send_item(skl_pkg::CMD_WRITE, {32'($urandom()), kv, kt, slot});
    endtask

    task automatic query_at(input logic [31:0] t, input bit ask_hold = 0);
        send_item(skl_pkg::CMD_QUERY,
                  {t, 32'($urandom()), 32'($urandom()), 8'($urandom())}, ask_hold);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.lookups_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_key_count(input int unsigned n);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= skl_pkg::CNT_W'(n);
        do @(posedge aclk); while (!cfg_ready);
        sb.set_key_count(n);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // shape 0: unsorted, 1: sorted with repeated times, else sorted
    task automatic fill_table(input int unsigned nw, input int unsigned shape);
        longint t, span, step;
        if ($urandom_range(0, 3) == 0)
            t = longint'(TIME_MIN);
        else
            t = longint'(int'($urandom())) / 2;
        span = (longint'(TIME_MAX) - t) / (nw + 1) * 2 + 1;
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        for (int unsigned i = 0; i < nw; i++) begin
            if (shape == 0) begin
                write_key(8'(i), $urandom(), $urandom());
            end else begin
                write_key(8'(i), t[31:0], $urandom());
                if (shape == 1 && $urandom_range(0, 1) == 0)
                    step = 0;
                else
                    step = $urandom_range(0, 32'(span));
                t += step;
                if (t > longint'(TIME_MAX))
                    t = longint'(TIME_MAX);
            end
        end
    endtask

    function automatic logic [31:0] pick_time(input int unsigned nw);
        int unsigned k;
        if (nw == 0)
            return $urandom();
        k = $urandom_range(0, nw - 1);
        case ($urandom_range(0, 7))
            0, 1:    return gen_time[k];
            2:       return gen_time[k] + 1;
            3:       return gen_time[k] - 1;
            4:       return ($urandom_range(0, 1) != 0) ? TIME_MIN : TIME_MAX;
            5:       return gen_time[k] + $urandom_range(0, 65535);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int unsigned n, nw, nq, r;
        bit          hold_phase;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table, then loads while no key is in use
        query_at(TIME_MIN);
        query_at(TIME_MAX);
        write_key(8'd0, 32'hFF9C_0000, TIME_MIN);
        write_key(8'd1, 32'h0000_0000, 32'h0000_0001);
        write_key(8'd2, 32'h0001_0000, 32'hFFFF_FFFF);
        write_key(8'd3, TIME_MAX, TIME_MAX);

        // single key
        set_key_count(1);
        query_at(TIME_MIN);
        query_at(32'h0000_0000);
        query_at(TIME_MAX);

        // before first, at first, between, exact inner hits, at last
        set_key_count(4);
        query_at(TIME_MIN);
        query_at(32'hFF9C_0000);
        query_at(32'hFFFF_FFFB);
        query_at(32'h0000_0000);
        query_at(32'h0000_0064);
        query_at(32'h0001_0000);
        query_at(32'h7FFF_FFFE);
        query_at(TIME_MAX);

        for (int unsigned ph = 0; items_sent < TARGET_ITEMS; ph++) begin
            case (ph)
                0: n = skl_pkg::MAX_KEYS;
                1: n = CNT_MAX;
                2: n = 2;
                3: n = 0;
                default: begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        n = $urandom_range(0, 1);
                    else if (r == 1)
                        n = $urandom_range(200, CNT_MAX);
                    else if (r < 5)
                        n = $urandom_range(17, 64);
                    else
                        n = $urandom_range(2, 16);
                end
            endcase
            nw = (n > skl_pkg::MAX_KEYS) ? skl_pkg::MAX_KEYS : n;
            hold_phase   = (ph == 5 || ph == 17);
            sender_burst = hold_phase || ($urandom_range(0, 3) == 0);

            set_key_count(n);
            fill_table(nw, $urandom_range(0, 9));

            nq = hold_phase ? 48 : (nw == 0 ? $urandom_range(4, 10) : $urandom_range(16, 40));
            for (int unsigned q = 0; q < nq; q++) begin
                if ($urandom_range(0, 15) == 0)
                    write_key(8'($urandom()), $urandom(), $urandom());
                else
                    query_at(pick_time(nw), hold_phase && q == 0);
            end
        end

        drain();
        if (sb.failures == 0 && sb.lookups_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
